[rtl/core/mfb_pkg.sv]
// Shared types, microcode and font for the monochrome frame buffer text block.
// Holds the item structs, operation codes, sequencer step codes and the 5x7 font.
// No dependencies.
`timescale 1ns / 1ps

package mfb_pkg;

   // Operation codes of an input item
   localparam logic [1:0] OP_PIXEL = 2'd0;
   localparam logic [1:0] OP_CHAR  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic       pixel_on;
      logic [7:0] char_code;
      logic [9:0] read_index;
   } mfb_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       status;
   } mfb_rsp_type;

   // Sequencer step codes (program addresses)
   localparam logic [3:0] U_IDLE = 4'd0;
   localparam logic [3:0] U_PIX0 = 4'd1;
   localparam logic [3:0] U_PIX1 = 4'd2;
   localparam logic [3:0] U_CHR0 = 4'd3;
   localparam logic [3:0] U_CHR1 = 4'd4;
   localparam logic [3:0] U_CHR2 = 4'd5;
   localparam logic [3:0] U_CHR3 = 4'd6;
   localparam logic [3:0] U_RESP = 4'd7;
   localparam logic [3:0] U_CLR0 = 4'd8;
   localparam logic [3:0] U_CLR1 = 4'd9;
   localparam logic [3:0] U_CLR2 = 4'd10;
   localparam logic [3:0] U_BOOT = 4'd11;
   localparam logic [3:0] U_RD0  = 4'd12;
   localparam logic [3:0] U_RD1  = 4'd13;

   // Jump conditions
   localparam logic [2:0] JC_NONE     = 3'd0;
   localparam logic [2:0] JC_ALWAYS   = 3'd1;
   localparam logic [2:0] JC_DISPATCH = 3'd2;
   localparam logic [2:0] JC_REJECT   = 3'd3;
   localparam logic [2:0] JC_MORE_COL = 3'd4;
   localparam logic [2:0] JC_MORE_CLR = 3'd5;
   localparam logic [2:0] JC_NOT_BOOT = 3'd6;

   // Store address / write data selects
   localparam logic [2:0] AS_PIXEL    = 3'd0;
   localparam logic [2:0] AS_GLYPH_LO = 3'd1;
   localparam logic [2:0] AS_GLYPH_HI = 3'd2;
   localparam logic [2:0] AS_INDEX    = 3'd3;
   localparam logic [2:0] AS_CLEAR    = 3'd4;

   // Glyph geometry: five font columns plus one blank spacing column
   localparam logic [2:0] FONT_COLS = 3'd5;
   localparam logic [2:0] COL_LAST  = 3'd5;
   localparam logic [8:0] GLYPH_SPAN = 9'd5;

   // Font slots for the punctuation and the blank glyph
   localparam logic [5:0] SLOT_DASH  = 6'd36;
   localparam logic [5:0] SLOT_COLON = 6'd37;
   localparam logic [5:0] SLOT_DOT   = 6'd38;
   localparam logic [5:0] SLOT_SLASH = 6'd39;
   localparam logic [5:0] SLOT_BLANK = 6'd40;

   typedef struct packed {
      logic [2:0] jump_cond;
      logic [3:0] target;
      logic       rd_en;
      logic [2:0] rd_sel;
      logic       wr_en;
      logic [2:0] wr_sel;
      logic       col_init;
      logic       col_inc;
      logic       clr_init;
      logic       clr_inc;
      logic       check;
      logic       capture;
      logic       respond;
      logic       boot_done;
   } mfb_uop_type;

   // 5x7 font, bit 0 is the top row; digits, letters, - : . / and blank
   localparam logic [0:40][0:4][7:0] MFB_FONT = {
      8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E,  8'h00, 8'h42, 8'h7F, 8'h40, 8'h00,
      8'h42, 8'h61, 8'h51, 8'h49, 8'h46,  8'h21, 8'h41, 8'h45, 8'h4B, 8'h31,
      8'h18, 8'h14, 8'h12, 8'h7F, 8'h10,  8'h27, 8'h45, 8'h45, 8'h45, 8'h39,
      8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30,  8'h01, 8'h71, 8'h09, 8'h05, 8'h03,
      8'h36, 8'h49, 8'h49, 8'h49, 8'h36,  8'h06, 8'h49, 8'h49, 8'h29, 8'h1E,
      8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E,  8'h7F, 8'h49, 8'h49, 8'h49, 8'h36,
      8'h3E, 8'h41, 8'h41, 8'h41, 8'h22,  8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C,
      8'h7F, 8'h49, 8'h49, 8'h49, 8'h41,  8'h7F, 8'h09, 8'h09, 8'h09, 8'h01,
      8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A,  8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F,
      8'h00, 8'h41, 8'h7F, 8'h41, 8'h00,  8'h20, 8'h40, 8'h41, 8'h3F, 8'h01,
      8'h7F, 8'h08, 8'h14, 8'h22, 8'h41,  8'h7F, 8'h40, 8'h40, 8'h40, 8'h40,
      8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F,  8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F,
      8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E,  8'h7F, 8'h09, 8'h09, 8'h09, 8'h06,
      8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E,  8'h7F, 8'h09, 8'h19, 8'h29, 8'h46,
      8'h46, 8'h49, 8'h49, 8'h49, 8'h31,  8'h01, 8'h01, 8'h7F, 8'h01, 8'h01,
      8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F,  8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F,
      8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F,  8'h63, 8'h14, 8'h08, 8'h14, 8'h63,
      8'h07, 8'h08, 8'h70, 8'h08, 8'h07,  8'h61, 8'h51, 8'h49, 8'h45, 8'h43,
      8'h08, 8'h08, 8'h08, 8'h08, 8'h08,  8'h00, 8'h36, 8'h36, 8'h00, 8'h00,
      8'h00, 8'h60, 8'h60, 8'h00, 8'h00,  8'h20, 8'h10, 8'h08, 8'h04, 8'h02,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   // ASCII code to font slot; lower case folds to upper, unknown is blank
   function automatic logic [5:0] mfb_glyph_slot(input logic [7:0] code);
      logic [7:0] up;
      logic [5:0] slot;
      up = code;
      if (code >= 8'h61 && code <= 8'h7A) begin
         up = code - 8'h20;
      end
      if (up >= 8'h30 && up <= 8'h39) begin
         slot = 6'(up - 8'h30);
      end else if (up >= 8'h41 && up <= 8'h5A) begin
         slot = 6'(up - 8'h41) + 6'd10;
      end else if (up == 8'h2D) begin
         slot = SLOT_DASH;
      end else if (up == 8'h3A) begin
         slot = SLOT_COLON;
      end else if (up == 8'h2E) begin
         slot = SLOT_DOT;
      end else if (up == 8'h2F) begin
         slot = SLOT_SLASH;
      end else begin
         slot = SLOT_BLANK;
      end
      return slot;
   endfunction

   // Control program: one word per step
   function automatic mfb_uop_type mfb_ucode(input logic [3:0] step);
      mfb_uop_type u;
      u = '0;
      unique case (step)
         U_IDLE: begin
            u.jump_cond = JC_DISPATCH;
         end
         // set pixel: check, read byte, write merged byte
         U_PIX0: begin
            u.check = 1'b1;  u.jump_cond = JC_REJECT;  u.target = U_RESP;
            u.rd_en = 1'b1;  u.rd_sel = AS_PIXEL;
         end
         U_PIX1: begin
            u.wr_en = 1'b1;  u.wr_sel = AS_PIXEL;
            u.jump_cond = JC_ALWAYS;  u.target = U_RESP;
         end
         // draw char: per column read/write upper page, then lower page
         U_CHR0: begin
            u.check = 1'b1;  u.col_init = 1'b1;
            u.jump_cond = JC_REJECT;  u.target = U_RESP;
         end
         U_CHR1: begin
            u.rd_en = 1'b1;  u.rd_sel = AS_GLYPH_LO;
         end
         U_CHR2: begin
            u.wr_en = 1'b1;  u.wr_sel = AS_GLYPH_LO;
            u.rd_en = 1'b1;  u.rd_sel = AS_GLYPH_HI;
         end
         U_CHR3: begin
            u.wr_en = 1'b1;  u.wr_sel = AS_GLYPH_HI;  u.col_inc = 1'b1;
            u.jump_cond = JC_MORE_COL;  u.target = U_CHR1;
         end
         U_RESP: begin
            u.respond = 1'b1;
            u.jump_cond = JC_ALWAYS;  u.target = U_IDLE;
         end
         // clear: one byte per step; also the pass after reset
         U_CLR0: begin
            u.clr_init = 1'b1;
         end
         U_CLR1: begin
            u.wr_en = 1'b1;  u.wr_sel = AS_CLEAR;  u.clr_inc = 1'b1;
            u.jump_cond = JC_MORE_CLR;  u.target = U_CLR1;
         end
         U_CLR2: begin
            u.jump_cond = JC_NOT_BOOT;  u.target = U_RESP;
         end
         U_BOOT: begin
            u.boot_done = 1'b1;
            u.jump_cond = JC_ALWAYS;  u.target = U_IDLE;
         end
         // read byte
         U_RD0: begin
            u.check = 1'b1;  u.jump_cond = JC_REJECT;  u.target = U_RESP;
            u.rd_en = 1'b1;  u.rd_sel = AS_INDEX;
         end
         U_RD1: begin
            u.capture = 1'b1;
            u.jump_cond = JC_ALWAYS;  u.target = U_RESP;
         end
         default: begin
            u.jump_cond = JC_ALWAYS;  u.target = U_IDLE;
         end
      endcase
      return u;
   endfunction

endpackage

[rtl/core/mfb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
`timescale 1ns / 1ps

module mfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/mono_framebuffer_text_draw.sv]
// Draw char takes three store steps per glyph column, six columns in all.
// One item at a time; busy drops in the cycle its result is shown, so the next
// item can be accepted then. The receiver cannot stall; the result lasts one cycle.
// Reset (synchronous) runs a clearing pass over all STORE_BYTES bytes, busy high.
// Uses mfb_pkg and mfb_ram.
`timescale 1ns / 1ps

module mono_framebuffer_text_draw
   import mfb_pkg::*;
#(
   parameter int PANEL_WIDTH  = 128,
   parameter int PANEL_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  mfb_req_type req_item,
   output logic        rsp_valid,
   output mfb_rsp_type rsp_item
);

   localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
   localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
   localparam int ADDR_WIDTH  = $clog2(STORE_BYTES);

   localparam logic [8:0]            WIDTH9     = 9'(PANEL_WIDTH);
   localparam logic [8:0]            HEIGHT9    = 9'(PANEL_HEIGHT);
   localparam logic [13:0]           STORE14    = 14'(STORE_BYTES);
   localparam logic [ADDR_WIDTH-1:0] ADDR_LAST  = ADDR_WIDTH'(STORE_BYTES - 1);
   localparam logic [ADDR_WIDTH-1:0] ADDR_PITCH = ADDR_WIDTH'(PANEL_WIDTH);

   // Sequencer and datapath registers
   logic [3:0]            pc_ff, pc_in;
   logic                  boot_ff, boot_in;
   mfb_req_type           item_ff, item_in;
   logic [5:0]            slot_ff, slot_in;
   logic [2:0]            col_ff, col_in;
   logic [ADDR_WIDTH-1:0] clr_ff, clr_in;
   logic [7:0]            data_ff, data_in;
   logic                  status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   mfb_rsp_type           rsp_item_ff, rsp_item_in;

   mfb_uop_type           uop;
   logic                  reject;

   logic [4:0]            page;
   logic [2:0]            shift;
   logic [8:0]            rows_left;
   logic [15:0]           row_keep;
   logic [7:0]            glyph_bits;
   logic [15:0]           glyph_mask;
   logic [15:0]           glyph_data;
   logic [7:0]            pixel_mask;

   logic [ADDR_WIDTH-1:0] pixel_addr;
   logic [ADDR_WIDTH-1:0] glyph_lo_addr;
   logic [ADDR_WIDTH-1:0] glyph_hi_addr;
   logic [ADDR_WIDTH-1:0] index_addr;

   logic                  ram_we;
   logic [ADDR_WIDTH-1:0] ram_wr_addr;
   logic [7:0]            ram_wr_data;
   logic [ADDR_WIDTH-1:0] ram_rd_addr;
   logic [7:0]            ram_rd_data;
   logic [7:0]            merge_mask;
   logic [7:0]            merge_bits;

   assign uop = mfb_ucode(pc_ff);

   // Position checks on the held item
   always_comb begin
      unique case (item_ff.operation)
         OP_PIXEL: reject = ({1'b0, item_ff.pos_x} >= WIDTH9) ||
                            ({1'b0, item_ff.pos_y} >= HEIGHT9);
         OP_CHAR:  reject = ({1'b0, item_ff.pos_x} + GLYPH_SPAN >= WIDTH9) ||
                            ({1'b0, item_ff.pos_y} >= HEIGHT9);
         OP_READ:  reject = ({4'd0, item_ff.read_index} >= STORE14);
         default:  reject = 1'b0;
      endcase
   end

   // Glyph column bits, spread over two pages and clipped at the panel bottom
   assign page       = item_ff.pos_y[7:3];
   assign shift      = item_ff.pos_y[2:0];
   assign rows_left  = HEIGHT9 - {1'b0, page, 3'b000};
   assign row_keep   = (rows_left >= 9'd16) ? 16'hFFFF
                                            : ((16'h0001 << rows_left[3:0]) - 16'h0001);
   assign glyph_bits = (col_ff < FONT_COLS) ? MFB_FONT[slot_ff][col_ff] : 8'h00;
   assign glyph_mask = (16'h007F << shift) & row_keep;
   assign glyph_data = {9'd0, glyph_bits[6:0]} << shift;
   assign pixel_mask = 8'h01 << shift;

   // Store addresses
   assign pixel_addr    = ADDR_WIDTH'(ADDR_WIDTH'(page) * ADDR_PITCH)
                          + ADDR_WIDTH'(item_ff.pos_x);
   assign glyph_lo_addr = pixel_addr + ADDR_WIDTH'(col_ff);
   assign glyph_hi_addr = glyph_lo_addr + ADDR_PITCH;
   assign index_addr    = ADDR_WIDTH'(item_ff.read_index);

   always_comb begin
      unique case (uop.rd_sel)
         AS_PIXEL:    ram_rd_addr = pixel_addr;
         AS_GLYPH_LO: ram_rd_addr = glyph_lo_addr;
         AS_GLYPH_HI: ram_rd_addr = glyph_hi_addr;
         AS_INDEX:    ram_rd_addr = index_addr;
         default:     ram_rd_addr = clr_ff;
      endcase
   end

   // Read-modify-write merge; clear writes zero
   always_comb begin
      unique case (uop.wr_sel)
         AS_PIXEL: begin
            ram_wr_addr = pixel_addr;
            merge_mask  = pixel_mask;
            merge_bits  = item_ff.pixel_on ? pixel_mask : 8'h00;
         end
         AS_GLYPH_LO: begin
            ram_wr_addr = glyph_lo_addr;
            merge_mask  = glyph_mask[7:0];
            merge_bits  = glyph_data[7:0];
         end
         AS_GLYPH_HI: begin
            ram_wr_addr = glyph_hi_addr;
            merge_mask  = glyph_mask[15:8];
            merge_bits  = glyph_data[15:8];
         end
         default: begin
            ram_wr_addr = clr_ff;
            merge_mask  = 8'hFF;
            merge_bits  = 8'h00;
         end
      endcase
      ram_wr_data = (ram_rd_data & ~merge_mask) | (merge_bits & merge_mask);
      // lower page untouched (or off the store) when no row of it is covered
      ram_we = uop.wr_en && !((uop.wr_sel == AS_GLYPH_HI) && (glyph_mask[15:8] == 8'h00));
   end

   mfb_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (uop.rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Step counter, jumps and datapath updates
   always_comb begin
      pc_in        = pc_ff + 4'd1;
      boot_in      = boot_ff;
      item_in      = item_ff;
      slot_in      = slot_ff;
      col_in       = col_ff;
      clr_in       = clr_ff;
      data_in      = data_ff;
      status_in    = status_ff;
      rsp_valid_in = uop.respond;
      rsp_item_in  = rsp_item_ff;

      unique case (uop.jump_cond)
         JC_ALWAYS:   pc_in = uop.target;
         JC_REJECT:   if (reject) pc_in = uop.target;
         JC_MORE_COL: if (col_ff != COL_LAST) pc_in = uop.target;
         JC_MORE_CLR: if (clr_ff != ADDR_LAST) pc_in = uop.target;
         JC_NOT_BOOT: if (!boot_ff) pc_in = uop.target;
         JC_DISPATCH: begin
            pc_in = pc_ff;
            if (start) begin
               item_in   = req_item;
               slot_in   = mfb_glyph_slot(req_item.char_code);
               data_in   = 8'h00;
               status_in = 1'b0;
               unique case (req_item.operation)
                  OP_PIXEL: pc_in = U_PIX0;
                  OP_CHAR:  pc_in = U_CHR0;
                  OP_CLEAR: pc_in = U_CLR0;
                  default:  pc_in = U_RD0;
               endcase
            end
         end
         default: ;
      endcase

      if (uop.col_init) col_in = 3'd0;
      if (uop.col_inc)  col_in = col_ff + 3'd1;
      if (uop.clr_init) clr_in = '0;
      if (uop.clr_inc)  clr_in = clr_ff + ADDR_WIDTH'(1);
      if (uop.check)    status_in = reject;
      if (uop.capture)  data_in = ram_rd_data;
      if (uop.boot_done) boot_in = 1'b0;
      if (uop.respond) begin
         rsp_item_in.read_data = data_ff;
         rsp_item_in.status    = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= U_CLR0;
         boot_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         boot_ff      <= boot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      slot_ff     <= slot_in;
      col_ff      <= col_in;
      clr_ff      <= clr_in;
      data_ff     <= data_in;
      status_ff   <= status_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy      = reset || (pc_ff != U_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Checks
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   a_write_in_store: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ({1'b0, ram_wr_addr} < (ADDR_WIDTH + 1)'(STORE_BYTES)))
      else $error("store write beyond the frame store");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status) |-> (rsp_item.read_data == 8'h00))
      else $error("rejected item carries nonzero data");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      ((pc_ff == U_CHR1) || (pc_ff == U_CHR2) || (pc_ff == U_CHR3)) |-> (col_ff <= COL_LAST))
      else $error("glyph column counter out of range");

endmodule
